// ----- sv/bba_pkg.sv -----
// ----------------------------------------------------------------------------
// bba_pkg: shared types and constants for the bucketed batch admission block
// Field widths, status and register codes, control state encoding and the
// structs that travel between the top level and the queue cells.
// ----------------------------------------------------------------------------
package bba_pkg;

  // Default sizing of the block
  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_MAX_BATCH   = 8;
  localparam int DEF_BLOCK_SIZE  = 16;
  localparam int DEF_MAX_PROMPT  = 4096;

  // Fixed field widths
  localparam int LEN_W     = 13;
  localparam int TAG_W     = 16;
  localparam int SEQ_W     = 16;
  localparam int BKT_W     = 13;
  localparam int BLK_W     = 9;
  localparam int FREE_W    = 13;
  localparam int NEED_W    = 14;
  localparam int MB_W      = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 13;
  localparam int NUM_BKT   = 4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BATCH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_A  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_B  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_C  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_D  = 3'd4;

  // Register reset values
  localparam logic [MB_W-1:0]  RST_MAX_BATCH = 4'd8;
  localparam logic [BKT_W-1:0] RST_BUCKET_A  = 13'd512;
  localparam logic [BKT_W-1:0] RST_BUCKET_B  = 13'd1024;
  localparam logic [BKT_W-1:0] RST_BUCKET_C  = 13'd2048;
  localparam logic [BKT_W-1:0] RST_BUCKET_D  = 13'd4096;

  // Input mode codes
  localparam logic MODE_SUBMIT = 1'b0;
  localparam logic MODE_STEP   = 1'b1;

  // Result status codes
  typedef enum logic [2:0] {
    ST_ACCEPTED = 3'd0,
    ST_FULL     = 3'd1,
    ST_ADMITTED = 3'd2,
    ST_TOO_LONG = 3'd3,
    ST_NONE     = 3'd4
  } bba_status_t;

  // Control sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PICK,
    S_CALC,
    S_CHECK
  } bba_state_t;

  // Queue commands broadcast to every cell
  typedef struct packed {
    logic push;    // load the cell at the tail
    logic remove;  // close up the queue over the removed position
  } bba_qctl_t;

  // Running longest-prompt record handed along the cell row
  typedef struct packed {
    logic             vld;
    logic [LEN_W-1:0] len;
    logic [TAG_W-1:0] tag;
  } bba_best_t;

endpackage

// ----- sv/bba_cell.sv -----
// ----------------------------------------------------------------------------
// bba_cell: one slot of the waiting-request queue
// Holds a prompt length and tag, shifts toward the head on removal, and keeps
// one stage of the longest-prompt search that runs along the row of cells.
// ----------------------------------------------------------------------------
module bba_cell #(
  parameter int QUEUE_DEPTH = bba_pkg::DEF_QUEUE_DEPTH,
  parameter int IDX         = 0
) (
  input  logic                                 clk,
  input  bba_pkg::bba_qctl_t                   ctl,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0]     count,
  input  logic [$clog2(QUEUE_DEPTH)-1:0]       rm_pos,
  input  logic [bba_pkg::LEN_W-1:0]            push_len,
  input  logic [bba_pkg::TAG_W-1:0]            push_tag,
  input  logic [bba_pkg::LEN_W-1:0]            nbr_len,
  input  logic [bba_pkg::TAG_W-1:0]            nbr_tag,
  output logic [bba_pkg::LEN_W-1:0]            len_o,
  output logic [bba_pkg::TAG_W-1:0]            tag_o,
  input  bba_pkg::bba_best_t                   prev_best,
  input  logic [$clog2(QUEUE_DEPTH)-1:0]       prev_pos,
  output bba_pkg::bba_best_t                   best_o,
  output logic [$clog2(QUEUE_DEPTH)-1:0]       best_pos_o
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int POS_W = $clog2(QUEUE_DEPTH);

  logic [bba_pkg::LEN_W-1:0] len_r, len_nxt;
  logic [bba_pkg::TAG_W-1:0] tag_r, tag_nxt;
  bba_pkg::bba_best_t        best_r, best_nxt;
  logic [POS_W-1:0]          pos_r, pos_nxt;
  logic                      own_vld;

  assign own_vld = CNT_W'(IDX) < count;

  // Load at the tail, shift from the neighbor behind on removal, else hold
  always_comb begin
    len_nxt = len_r;
    tag_nxt = tag_r;
    if (ctl.push && (CNT_W'(IDX) == count)) begin
      len_nxt = push_len;
      tag_nxt = push_tag;
    end else if (ctl.remove && (POS_W'(IDX) >= rm_pos)) begin
      len_nxt = nbr_len;
      tag_nxt = nbr_tag;
    end
  end

  // Take over the record when this entry is valid and either no record is held yet or it is strictly longer
  always_comb begin
    best_nxt = prev_best;
    pos_nxt  = prev_pos;
    if (own_vld && (!prev_best.vld || (len_r > prev_best.len))) begin
      best_nxt.vld = 1'b1;
      best_nxt.len = len_r;
      best_nxt.tag = tag_r;
      pos_nxt      = POS_W'(IDX);
    end
  end

  always_ff @(posedge clk) begin
    len_r  <= len_nxt;
    tag_r  <= tag_nxt;
    best_r <= best_nxt;
    pos_r  <= pos_nxt;
  end

  assign len_o      = len_r;
  assign tag_o      = tag_r;
  assign best_o     = best_r;
  assign best_pos_o = pos_r;

endmodule

// ----- sv/bba_blkdiv.sv -----
// ----------------------------------------------------------------------------
// bba_blkdiv: cache block count for a prompt
// Registers ceil(len / BLOCK_SIZE), formed as a multiply by a scaled
// reciprocal that is exact over the whole length range.
// ----------------------------------------------------------------------------
module bba_blkdiv #(
  parameter int BLOCK_SIZE = bba_pkg::DEF_BLOCK_SIZE
) (
  input  logic                       clk,
  input  logic [bba_pkg::LEN_W-1:0]  len,
  output logic [bba_pkg::NEED_W-1:0] need
);

  localparam int N     = bba_pkg::NEED_W;
  localparam int L     = $clog2(BLOCK_SIZE);
  localparam int S     = N + L;
  localparam int PW    = S + N;
  localparam int RECIP = ((1 << S) + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam logic [PW-1:0] RECIP_W = PW'(RECIP);
  localparam logic [N-1:0]  ROUND_W = N'(BLOCK_SIZE - 1);

  logic [N-1:0]  num;
  logic [PW-1:0] prod;
  logic [N-1:0]  need_r, need_nxt;

  // Round up, then scale by the reciprocal and drop the fraction
  assign num      = N'(len) + ROUND_W;
  assign prod     = PW'(num) * RECIP_W;
  assign need_nxt = prod[S +: N];

  always_ff @(posedge clk) begin
    need_r <= need_nxt;
  end

  assign need = need_r;

endmodule

// ----- sv/bucketed_batch_admission.sv -----
// ----------------------------------------------------------------------------
// bucketed_batch_admission: bucketed, block-budgeted admission queue
// Queues tagged requests and admits batches from the head under a bucket
// length, a batch limit and a cache block budget.
// ----------------------------------------------------------------------------
// A submit (in_mode 0) gives one result, registered, in the cycle after it
// is taken; a step on an empty queue also answers in the cycle after. Any
// other step holds busy while the longest-prompt search runs down the row of
// queue cells (S_SCAN), then takes each examined head request through S_CALC
// (block count multiply) and S_CHECK (the fit check); a drop of an oversized
// request ends after the search, in S_PICK.
// Results come one per strobe and the receiver cannot stall: out_valid is
// high for exactly one cycle per result and must be captured then. The last
// result of an item carries out_last. Write configuration only while idle.
// ----------------------------------------------------------------------------
module bucketed_batch_admission #(
  parameter int QUEUE_DEPTH = bba_pkg::DEF_QUEUE_DEPTH,
  parameter int MAX_BATCH   = bba_pkg::DEF_MAX_BATCH,
  parameter int BLOCK_SIZE  = bba_pkg::DEF_BLOCK_SIZE,
  parameter int MAX_PROMPT  = bba_pkg::DEF_MAX_PROMPT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [bba_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bba_pkg::CFG_DAT_W-1:0]     cfg_wdata,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_mode,
  input  logic [bba_pkg::LEN_W-1:0]         in_prompt_len,
  input  logic [bba_pkg::FREE_W-1:0]        in_free_blocks,
  output logic                              out_valid,
  output logic [2:0]                        out_status,
  output logic [bba_pkg::TAG_W-1:0]         out_req_tag,
  output logic [bba_pkg::SEQ_W-1:0]         out_seq_number,
  output logic [bba_pkg::BKT_W-1:0]         out_bucket_size,
  output logic [bba_pkg::BLK_W-1:0]         out_blocks_needed,
  output logic                              out_last
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int POS_W = $clog2(QUEUE_DEPTH);
  localparam int NB_W  = $clog2(MAX_BATCH + 16);
  localparam int LEN_W = bba_pkg::LEN_W;
  localparam int TAG_W = bba_pkg::TAG_W;
  localparam int SEQ_W = bba_pkg::SEQ_W;
  localparam int BKT_W = bba_pkg::BKT_W;
  localparam int BLK_W = bba_pkg::BLK_W;
  localparam int NEED_W = bba_pkg::NEED_W;
  localparam int FREE_W = bba_pkg::FREE_W;

  // Sequencer and bookkeeping registers
  bba_pkg::bba_state_t state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [TAG_W-1:0]    tag_ctr_r, tag_ctr_nxt;
  logic [SEQ_W-1:0]    seq_ctr_r, seq_ctr_nxt;
  logic [FREE_W-1:0]   budget_r, budget_nxt;
  logic [BKT_W-1:0]    bsel_r, bsel_nxt;
  logic [NB_W-1:0]     nadm_r, nadm_nxt;
  logic [POS_W-1:0]    scan_r, scan_nxt;

  // Admitted result held until it is known whether it is the last one
  logic                pend_vld_r, pend_vld_nxt;
  logic [TAG_W-1:0]    pend_tag_r, pend_tag_nxt;
  logic [SEQ_W-1:0]    pend_seq_r, pend_seq_nxt;
  logic [NEED_W-1:0]   pend_need_r, pend_need_nxt;

  // Configuration
  logic [bba_pkg::MB_W-1:0] max_batch_r;
  logic [BKT_W-1:0]         bucket_r [bba_pkg::NUM_BKT];

  // Result register
  logic                 ov_r, ov_nxt;
  bba_pkg::bba_status_t ost_r, ost_nxt;
  logic [TAG_W-1:0]     otag_r, otag_nxt;
  logic [SEQ_W-1:0]     oseq_r, oseq_nxt;
  logic [BKT_W-1:0]     obkt_r, obkt_nxt;
  logic [BLK_W-1:0]     oblk_r, oblk_nxt;
  logic                 olast_r, olast_nxt;

  // Cell row wiring
  bba_pkg::bba_qctl_t  qctl;
  logic [POS_W-1:0]    rm_pos;
  logic [LEN_W-1:0]    cell_len [QUEUE_DEPTH];
  logic [TAG_W-1:0]    cell_tag [QUEUE_DEPTH];
  bba_pkg::bba_best_t  cell_best [QUEUE_DEPTH];
  logic [POS_W-1:0]    cell_pos [QUEUE_DEPTH];

  logic                accept;
  logic                too_long_in;
  logic                full;
  logic [NEED_W-1:0]   need;
  logic                bkt_found;
  logic [BKT_W-1:0]    bkt_pick;
  logic [NB_W-1:0]     lim;
  logic                stop;
  bba_pkg::bba_best_t  longest;
  logic [POS_W-1:0]    longest_pos;

  assign busy        = state_r != bba_pkg::S_IDLE;
  assign accept      = start && !busy;
  assign too_long_in = 32'(in_prompt_len) > MAX_PROMPT;
  assign full        = count_r == CNT_W'(QUEUE_DEPTH);
  assign longest     = cell_best[QUEUE_DEPTH-1];
  assign longest_pos = cell_pos[QUEUE_DEPTH-1];

  // Queue cells, head at index zero
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic [LEN_W-1:0]   nbr_len;
    logic [TAG_W-1:0]   nbr_tag;
    bba_pkg::bba_best_t prev_best;
    logic [POS_W-1:0]   prev_pos;

    if (g == QUEUE_DEPTH - 1) begin : g_tail
      assign nbr_len = '0;
      assign nbr_tag = '0;
    end else begin : g_mid
      assign nbr_len = cell_len[g+1];
      assign nbr_tag = cell_tag[g+1];
    end

    if (g == 0) begin : g_first
      assign prev_best = '0;
      assign prev_pos  = '0;
    end else begin : g_rest
      assign prev_best = cell_best[g-1];
      assign prev_pos  = cell_pos[g-1];
    end

    bba_cell #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .IDX        (g)
    ) u_cell (
      .clk       (clk),
      .ctl       (qctl),
      .count     (count_r),
      .rm_pos    (rm_pos),
      .push_len  (in_prompt_len),
      .push_tag  (tag_ctr_r),
      .nbr_len   (nbr_len),
      .nbr_tag   (nbr_tag),
      .len_o     (cell_len[g]),
      .tag_o     (cell_tag[g]),
      .prev_best (prev_best),
      .prev_pos  (prev_pos),
      .best_o    (cell_best[g]),
      .best_pos_o(cell_pos[g])
    );
  end

  // Block count of the head request, registered from the head length
  bba_blkdiv #(
    .BLOCK_SIZE(BLOCK_SIZE)
  ) u_blkdiv (
    .clk (clk),
    .len (cell_len[0]),
    .need(need)
  );

  // Pick the smallest enabled bucket that holds the longest prompt
  always_comb begin
    bkt_found = 1'b0;
    bkt_pick  = '0;
    for (int i = 0; i < bba_pkg::NUM_BKT; i++) begin
      if ((bucket_r[i] != '0) && (bucket_r[i] >= longest.len) &&
          (!bkt_found || (bucket_r[i] < bkt_pick))) begin
        bkt_found = 1'b1;
        bkt_pick  = bucket_r[i];
      end
    end
  end

  // Saturate the batch limit and test the head against it, the bucket length and the block budget
  assign lim  = (NB_W'(max_batch_r) > NB_W'(MAX_BATCH)) ? NB_W'(MAX_BATCH)
                                                        : NB_W'(max_batch_r);
  assign stop = (nadm_r == lim) || (count_r == '0) || (cell_len[0] > bsel_r) ||
                (need > NEED_W'(budget_r));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bba_pkg::S_IDLE: begin
        if (accept && (in_mode == bba_pkg::MODE_STEP) && (count_r != '0)) begin
          state_nxt = bba_pkg::S_SCAN;
        end
      end
      bba_pkg::S_SCAN: begin
        if (scan_r == '0) begin
          state_nxt = bba_pkg::S_PICK;
        end
      end
      bba_pkg::S_PICK: begin
        state_nxt = bkt_found ? bba_pkg::S_CALC : bba_pkg::S_IDLE;
      end
      bba_pkg::S_CALC: begin
        state_nxt = bba_pkg::S_CHECK;
      end
      bba_pkg::S_CHECK: begin
        state_nxt = stop ? bba_pkg::S_IDLE : bba_pkg::S_CALC;
      end
      default: begin
        state_nxt = bba_pkg::S_IDLE;
      end
    endcase
  end

  // Queue commands, bookkeeping and results
  always_comb begin
    qctl          = '0;
    rm_pos        = '0;
    count_nxt     = count_r;
    tag_ctr_nxt   = tag_ctr_r;
    seq_ctr_nxt   = seq_ctr_r;
    budget_nxt    = budget_r;
    bsel_nxt      = bsel_r;
    nadm_nxt      = nadm_r;
    scan_nxt      = scan_r;
    pend_vld_nxt  = pend_vld_r;
    pend_tag_nxt  = pend_tag_r;
    pend_seq_nxt  = pend_seq_r;
    pend_need_nxt = pend_need_r;
    ov_nxt        = 1'b0;
    ost_nxt       = bba_pkg::ST_ACCEPTED;
    otag_nxt      = '0;
    oseq_nxt      = '0;
    obkt_nxt      = '0;
    oblk_nxt      = '0;
    olast_nxt     = 1'b0;
    case (state_r)
      bba_pkg::S_IDLE: begin
        if (accept && (in_mode == bba_pkg::MODE_SUBMIT)) begin
          ov_nxt    = 1'b1;
          olast_nxt = 1'b1;
          if (too_long_in) begin
            ost_nxt = bba_pkg::ST_TOO_LONG;
          end else if (full) begin
            ost_nxt = bba_pkg::ST_FULL;
          end else begin
            qctl.push   = 1'b1;
            ost_nxt     = bba_pkg::ST_ACCEPTED;
            otag_nxt    = tag_ctr_r;
            tag_ctr_nxt = tag_ctr_r + 1'b1;
            count_nxt   = count_r + 1'b1;
          end
        end else if (accept) begin
          if (count_r == '0) begin
            ov_nxt    = 1'b1;
            olast_nxt = 1'b1;
            ost_nxt   = bba_pkg::ST_NONE;
          end else begin
            budget_nxt   = in_free_blocks;
            nadm_nxt     = '0;
            scan_nxt     = POS_W'(QUEUE_DEPTH - 1);
            pend_vld_nxt = 1'b0;
          end
        end
      end
      bba_pkg::S_SCAN: begin
        scan_nxt = scan_r - 1'b1;
      end
      bba_pkg::S_PICK: begin
        if (bkt_found) begin
          bsel_nxt = bkt_pick;
        end else begin
          // drop the longest request and close up behind it
          qctl.remove = 1'b1;
          rm_pos      = longest_pos;
          count_nxt   = count_r - 1'b1;
          ov_nxt      = 1'b1;
          olast_nxt   = 1'b1;
          ost_nxt     = bba_pkg::ST_TOO_LONG;
          otag_nxt    = longest.tag;
        end
      end
      bba_pkg::S_CALC: begin
      end
      bba_pkg::S_CHECK: begin
        if (!stop) begin
          // admit the head; release the previous admission as not last
          qctl.remove   = 1'b1;
          count_nxt     = count_r - 1'b1;
          budget_nxt    = budget_r - FREE_W'(need);
          seq_ctr_nxt   = seq_ctr_r + 1'b1;
          nadm_nxt      = nadm_r + 1'b1;
          ov_nxt        = pend_vld_r;
          ost_nxt       = bba_pkg::ST_ADMITTED;
          otag_nxt      = pend_tag_r;
          oseq_nxt      = pend_seq_r;
          obkt_nxt      = bsel_r;
          oblk_nxt      = pend_need_r[BLK_W-1:0];
          pend_vld_nxt  = 1'b1;
          pend_tag_nxt  = cell_tag[0];
          pend_seq_nxt  = seq_ctr_r;
          pend_need_nxt = need;
        end else begin
          ov_nxt    = 1'b1;
          olast_nxt = 1'b1;
          obkt_nxt  = bsel_r;
          if (pend_vld_r) begin
            ost_nxt  = bba_pkg::ST_ADMITTED;
            otag_nxt = pend_tag_r;
            oseq_nxt = pend_seq_r;
            oblk_nxt = pend_need_r[BLK_W-1:0];
          end else begin
            ost_nxt = bba_pkg::ST_NONE;
          end
          pend_vld_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= bba_pkg::S_IDLE;
      count_r    <= '0;
      tag_ctr_r  <= '0;
      seq_ctr_r  <= '0;
      pend_vld_r <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      tag_ctr_r  <= tag_ctr_nxt;
      seq_ctr_r  <= seq_ctr_nxt;
      pend_vld_r <= pend_vld_nxt;
      ov_r       <= ov_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    budget_r    <= budget_nxt;
    bsel_r      <= bsel_nxt;
    nadm_r      <= nadm_nxt;
    scan_r      <= scan_nxt;
    pend_tag_r  <= pend_tag_nxt;
    pend_seq_r  <= pend_seq_nxt;
    pend_need_r <= pend_need_nxt;
    ost_r       <= ost_nxt;
    otag_r      <= otag_nxt;
    oseq_r      <= oseq_nxt;
    obkt_r      <= obkt_nxt;
    oblk_r      <= oblk_nxt;
    olast_r     <= olast_nxt;
  end

  // Configuration writes; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_batch_r <= bba_pkg::RST_MAX_BATCH;
      bucket_r[0] <= bba_pkg::RST_BUCKET_A;
      bucket_r[1] <= bba_pkg::RST_BUCKET_B;
      bucket_r[2] <= bba_pkg::RST_BUCKET_C;
      bucket_r[3] <= bba_pkg::RST_BUCKET_D;
    end else if (cfg_we) begin
      case (cfg_index)
        bba_pkg::CFG_MAX_BATCH: max_batch_r <= cfg_wdata[bba_pkg::MB_W-1:0];
        bba_pkg::CFG_BUCKET_A:  bucket_r[0] <= cfg_wdata;
        bba_pkg::CFG_BUCKET_B:  bucket_r[1] <= cfg_wdata;
        bba_pkg::CFG_BUCKET_C:  bucket_r[2] <= cfg_wdata;
        bba_pkg::CFG_BUCKET_D:  bucket_r[3] <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign out_valid         = ov_r;
  assign out_status        = ost_r;
  assign out_req_tag       = otag_r;
  assign out_seq_number    = oseq_r;
  assign out_bucket_size   = obkt_r;
  assign out_blocks_needed = oblk_r;
  assign out_last          = olast_r;

endmodule

// ----- verif/bucketed_batch_admission_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bucketed_batch_admission_test: self-checking bench for the admission queue
// Drives submit and step commands, keeps a shadow copy of the waiting queue,
// the tag and sequence counters and the registers, and compares every result
// strobe against the outcome that the shadow copy gives for that command.
// ----------------------------------------------------------------------------
module bucketed_batch_admission_test;

  localparam int CLK_HALF  = 6;
  localparam int DEPTH     = bba_pkg::DEF_QUEUE_DEPTH;
  localparam int BATCH_CAP = bba_pkg::DEF_MAX_BATCH;
  localparam int BLK_SIZE  = bba_pkg::DEF_BLOCK_SIZE;
  localparam int PROMPT_CAP = bba_pkg::DEF_MAX_PROMPT;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES = 2 * DEPTH + 8 + 2 * BATCH_CAP;
  localparam int ROUND_ITEMS = 36;
  localparam int MAX_REPORTS = 10;
  localparam int LEN_W     = bba_pkg::LEN_W;
  localparam int TAG_W     = bba_pkg::TAG_W;
  localparam int SEQ_W     = bba_pkg::SEQ_W;
  localparam int BKT_W     = bba_pkg::BKT_W;
  localparam int BLK_W     = bba_pkg::BLK_W;
  localparam int FREE_W    = bba_pkg::FREE_W;
  localparam int MB_W      = bba_pkg::MB_W;
  localparam int CFG_IDX_W = bba_pkg::CFG_IDX_W;
  localparam int CFG_DAT_W = bba_pkg::CFG_DAT_W;
  localparam int NUM_BKT   = bba_pkg::NUM_BKT;
  // register indexes past the list, which the block must ignore
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = 3'd7;

  typedef struct packed {
    bba_pkg::bba_status_t status;
    logic [TAG_W-1:0]   tag;
    logic [SEQ_W-1:0]   seq;
    logic [BKT_W-1:0]   bucket;
    logic [BLK_W-1:0]   blocks;
    logic               last;
  } outcome_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_wdata;
  logic                 start;
  logic                 busy;
  logic                 in_mode;
  logic [LEN_W-1:0]     in_prompt_len;
  logic [FREE_W-1:0]    in_free_blocks;
  logic                 out_valid;
  logic [2:0]           out_status;
  logic [TAG_W-1:0]     out_req_tag;
  logic [SEQ_W-1:0]     out_seq_number;
  logic [BKT_W-1:0]     out_bucket_size;
  logic [BLK_W-1:0]     out_blocks_needed;
  logic                 out_last;

  // shadow of the block: waiting queue, counters and registers
  logic [LEN_W-1:0] waiting_len[$];
  logic [TAG_W-1:0] waiting_tag[$];
  logic [TAG_W-1:0] next_tag;
  logic [SEQ_W-1:0] next_seq;
  logic [MB_W-1:0]  batch_shadow;
  logic [BKT_W-1:0] bucket_shadow[NUM_BKT];

  outcome_t pending_outcomes[$];

  int sender_idle_pct;
  int mismatches;
  int commands_sent;
  int results_seen;
  int admitted_seen;
  int dropped_seen;
  int full_seen;
  int none_seen;

  bucketed_batch_admission u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .start             (start),
    .busy              (busy),
    .in_mode           (in_mode),
    .in_prompt_len     (in_prompt_len),
    .in_free_blocks    (in_free_blocks),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_req_tag       (out_req_tag),
    .out_seq_number    (out_seq_number),
    .out_bucket_size   (out_bucket_size),
    .out_blocks_needed (out_blocks_needed),
    .out_last          (out_last)
  );

  always #(CLK_HALF) clk = ~clk;

  // record one failure, print details for the first few only
  task automatic report_failure(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("[%0t] ERROR: %s", $realtime, what);
    end
  endtask

  // work out the results of one accepted command and queue them
  task automatic compute_outcomes(input logic mode, input logic [LEN_W-1:0] len,
                                  input logic [FREE_W-1:0] free);
    outcome_t res[$];
    outcome_t r;
    int longest;
    int pos;
    int bucket;
    int limit;
    int budget;
    int need;
    int taken;
    bit found;
    r = '0;
    if (mode == bba_pkg::MODE_SUBMIT) begin
      if (int'(len) > PROMPT_CAP) begin
        r.status = bba_pkg::ST_TOO_LONG;
      end else if (waiting_len.size() >= DEPTH) begin
        r.status = bba_pkg::ST_FULL;
      end else begin
        waiting_len = {waiting_len, len};
        waiting_tag = {waiting_tag, next_tag};
        r.status = bba_pkg::ST_ACCEPTED;
        r.tag = next_tag;
        next_tag = next_tag + 1'b1;
      end
      res = {res, r};
    end else if (waiting_len.size() == 0) begin
      r.status = bba_pkg::ST_NONE;
      res = {res, r};
    end else begin
      // find the first waiting request of greatest length
      longest = 0;
      pos = 0;
      for (int i = 0; i < waiting_len.size(); i++) begin
        if (i == 0 || int'(waiting_len[i]) > longest) begin
          longest = waiting_len[i];
          pos = i;
        end
      end
      // pick the smallest enabled bucket that holds it
      found = 1'b0;
      bucket = 0;
      for (int b = 0; b < NUM_BKT; b++) begin
        if (bucket_shadow[b] != 0 && int'(bucket_shadow[b]) >= longest &&
            (!found || int'(bucket_shadow[b]) < bucket)) begin
          bucket = bucket_shadow[b];
          found = 1'b1;
        end
      end
      if (!found) begin
        // drop the oversized request, the rest close up
        r.status = bba_pkg::ST_TOO_LONG;
        r.tag = waiting_tag[pos];
        waiting_len.delete(pos);
        waiting_tag.delete(pos);
        res = {res, r};
      end else begin
        limit = (batch_shadow > BATCH_CAP) ? BATCH_CAP : int'(batch_shadow);
        budget = free;
        taken = 0;
        while (waiting_len.size() > 0 && taken < limit) begin
          need = (int'(waiting_len[0]) + BLK_SIZE - 1) / BLK_SIZE;
          if (int'(waiting_len[0]) > bucket || need > budget) break;
          budget -= need;
          r = '0;
          r.status = bba_pkg::ST_ADMITTED;
          r.tag = waiting_tag[0];
          r.seq = next_seq;
          r.bucket = BKT_W'(bucket);
          r.blocks = BLK_W'(need);
          res = {res, r};
          next_seq = next_seq + 1'b1;
          waiting_len.delete(0);
          waiting_tag.delete(0);
          taken++;
        end
        if (taken == 0) begin
          r = '0;
          r.status = bba_pkg::ST_NONE;
          r.bucket = BKT_W'(bucket);
          res = {res, r};
        end
      end
    end
    r = res[res.size() - 1];
    r.last = 1'b1;
    res[res.size() - 1] = r;
    foreach (res[i]) pending_outcomes = {pending_outcomes, res[i]};
  endtask

  // write one register at a falling edge and mirror it in the shadow
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_index <= CFG_IDX_W'($urandom_range(7));
    cfg_wdata <= CFG_DAT_W'($urandom_range(8191));
    if (idx == bba_pkg::CFG_MAX_BATCH) begin
      batch_shadow = data[MB_W-1:0];
    end else if (idx <= bba_pkg::CFG_BUCKET_D) begin
      bucket_shadow[idx - bba_pkg::CFG_BUCKET_A] = data[BKT_W-1:0];
    end
  endtask

  task automatic write_all(input int mb, input int a, input int b, input int c, input int d);
    write_reg(bba_pkg::CFG_MAX_BATCH, CFG_DAT_W'(mb));
    write_reg(bba_pkg::CFG_BUCKET_A, CFG_DAT_W'(a));
    write_reg(bba_pkg::CFG_BUCKET_B, CFG_DAT_W'(b));
    write_reg(bba_pkg::CFG_BUCKET_C, CFG_DAT_W'(c));
    write_reg(bba_pkg::CFG_BUCKET_D, CFG_DAT_W'(d));
  endtask

  // send one command, idling first as the current pace asks
  task automatic send_command(input logic mode, input logic [LEN_W-1:0] len,
                              input logic [FREE_W-1:0] free);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < sender_idle_pct) gap++;
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
      in_mode <= 1'($urandom_range(1));
      in_prompt_len <= LEN_W'($urandom_range(8191));
      in_free_blocks <= FREE_W'($urandom_range(8191));
    end
    @(negedge clk);
    start <= 1'b1;
    in_mode <= mode;
    in_prompt_len <= len;
    in_free_blocks <= free;
    // hold until the transfer happens
    @(posedge clk);
    while (busy) @(posedge clk);
    commands_sent++;
    compute_outcomes(mode, len, free);
  endtask

  task automatic submit(input int len);
    send_command(bba_pkg::MODE_SUBMIT, LEN_W'(len), FREE_W'($urandom_range(8191)));
  endtask

  task automatic step(input int free);
    send_command(bba_pkg::MODE_STEP, LEN_W'($urandom_range(8191)), FREE_W'(free));
  endtask

  // drop start and wait until every expected result has come back
  task automatic wait_for_results();
    @(negedge clk);
    start <= 1'b0;
    @(posedge clk);
    while (pending_outcomes.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 55) return $urandom_range(1, 600);
    if (r < 75) return $urandom_range(0, PROMPT_CAP);
    if (r < 88) return $urandom_range(1) ? 0 : PROMPT_CAP;
    return $urandom_range(PROMPT_CAP + 1, 8191);
  endfunction

  function automatic int pick_free();
    int r;
    r = $urandom_range(99);
    if (r < 40) return $urandom_range(64);
    if (r < 75) return $urandom_range(600);
    if (r < 85) return 0;
    return $urandom_range(8191);
  endfunction

  // register settings used between rounds of random traffic
  task automatic apply_setting(input int k);
    int bk[NUM_BKT];
    case (k)
      0: write_all(bba_pkg::RST_MAX_BATCH, bba_pkg::RST_BUCKET_A, bba_pkg::RST_BUCKET_B,
                   bba_pkg::RST_BUCKET_C, bba_pkg::RST_BUCKET_D);
      1: write_all(1, 16, 32, 64, 128);
      2: write_all(15, 0, 4096, 0, 0);
      4: write_all(0, 512, 1024, 2048, 4096);
      5: write_all(8, 0, 0, 0, 0);
      6: write_all(8, 8191, 1, 300, 2000);
      default: begin
        foreach (bk[i]) bk[i] = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 4096);
        write_all($urandom_range(15), bk[0], bk[1], bk[2], bk[3]);
        write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)),
                  CFG_DAT_W'($urandom_range(8191)));
      end
    endcase
  endtask

  // empty step, zero and maximum lengths, refusals and a full queue
  task automatic test_fill_and_limits();
    sender_idle_pct = 30;
    step($urandom_range(8191));
    submit(0);
    submit(PROMPT_CAP);
    submit(8191);
    submit(PROMPT_CAP + 1);
    repeat (DEPTH - 2) submit($urandom_range(1, 100));
    submit($urandom_range(1, 100));
    // zero-length head needs no blocks, the next one does not fit
    step(0);
    step(8191);
    wait_for_results();
  endtask

  // drop of an oversized request, batch limit of zero and saturation
  task automatic test_drop_and_batch_limit();
    write_all(0, 100, 0, 0, 0);
    write_reg(CFG_SPARE_FIRST, CFG_DAT_W'(8191));
    write_reg(CFG_SPARE_LAST, CFG_DAT_W'(8191));
    submit(200);
    step(8191);
    step(8191);
    wait_for_results();
    write_reg(bba_pkg::CFG_MAX_BATCH, CFG_DAT_W'(15));
    step(0);
    step(8191);
    wait_for_results();
  endtask

  // bursts of submits followed by steps, with some noise commands
  task automatic test_random_traffic();
    int pace[3] = '{30, 72, 0};
    int sent;
    int burst;
    int steps;
    for (int p = 0; p < 3; p++) begin
      sender_idle_pct = pace[p];
      for (int rnd = 0; rnd < 3; rnd++) begin
        wait_for_results();
        apply_setting(3 * p + rnd);
        sent = 0;
        while (sent < ROUND_ITEMS) begin
          if ($urandom_range(99) < 3) wait_for_results();
          if ($urandom_range(99) < 10) begin
            send_command(1'($urandom_range(1)), LEN_W'($urandom_range(8191)),
                         FREE_W'($urandom_range(8191)));
            sent++;
          end else begin
            burst = ($urandom_range(7) == 0) ? $urandom_range(1, DEPTH + 2)
                                             : $urandom_range(1, 5);
            steps = $urandom_range(1, 2);
            repeat (burst) submit(pick_len());
            repeat (steps) step(pick_free());
            sent += burst + steps;
          end
        end
      end
    end
    wait_for_results();
  endtask

  // compare every result strobe with the oldest expectation
  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    if (rst_n && out_valid) begin
      got = '{bba_pkg::bba_status_t'(out_status), out_req_tag, out_seq_number,
              out_bucket_size, out_blocks_needed, out_last};
      results_seen++;
      case (got.status)
        bba_pkg::ST_ADMITTED: admitted_seen++;
        bba_pkg::ST_TOO_LONG: dropped_seen++;
        bba_pkg::ST_FULL:     full_seen++;
        bba_pkg::ST_NONE:     none_seen++;
        default: ;
      endcase
      if (pending_outcomes.size() == 0) begin
        report_failure($sformatf("unexpected result status=%0d tag=%0d seq=%0d",
                                 got.status, got.tag, got.seq));
      end else begin
        want = pending_outcomes[0];
        pending_outcomes.delete(0);
        if (got !== want) begin
          report_failure($sformatf({"result mismatch exp st=%0d tag=%0d seq=%0d bkt=%0d ",
                                    "blk=%0d last=%0d got st=%0d tag=%0d seq=%0d bkt=%0d ",
                                    "blk=%0d last=%0d"},
                                   want.status, want.tag, want.seq, want.bucket,
                                   want.blocks, want.last, got.status, got.tag, got.seq,
                                   got.bucket, got.blocks, got.last));
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("bucketed_batch_admission verification failed");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    start = 1'b0;
    in_mode = bba_pkg::MODE_SUBMIT;
    in_prompt_len = '0;
    in_free_blocks = '0;
    next_tag = '0;
    next_seq = '0;
    batch_shadow = bba_pkg::RST_MAX_BATCH;
    bucket_shadow[0] = bba_pkg::RST_BUCKET_A;
    bucket_shadow[1] = bba_pkg::RST_BUCKET_B;
    bucket_shadow[2] = bba_pkg::RST_BUCKET_C;
    bucket_shadow[3] = bba_pkg::RST_BUCKET_D;
    sender_idle_pct = 0;
    mismatches = 0;
    commands_sent = 0;
    results_seen = 0;
    admitted_seen = 0;
    dropped_seen = 0;
    full_seen = 0;
    none_seen = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_fill_and_limits();
    test_drop_and_batch_limit();
    test_random_traffic();

    // let any stray strobe show up before judging
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_outcomes.size() != 0) begin
      report_failure($sformatf("%0d expected results never arrived", pending_outcomes.size()));
    end
    $display("Covered %0d commands, %0d results: %0d admitted, %0d dropped or refused,",
             commands_sent, results_seen, admitted_seen, dropped_seen);
    $display("  %0d queue-full, %0d with nothing admitted; %0d failures",
             full_seen, none_seen, mismatches);
    if (mismatches == 0) begin
      $display("bucketed_batch_admission verification clean");
    end else begin
      $display("bucketed_batch_admission verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/bba_pkg.sv
sv/bba_cell.sv
sv/bba_blkdiv.sv
sv/bucketed_batch_admission.sv
verif/bucketed_batch_admission_test.sv
